// ===== rtl/ethp_pkg.sv =====
// shared types and constants of the ethernet / ipv4 / tcp header parser
package ethp_pkg;

	// default frame length limit, bytes beyond it are not inspected
	localparam int MAX_FRAME_BYTES_DEF = 2048;

	// depth of the queue between the byte parser and the result stage
	localparam int QUEUE_DEPTH = 2;

	// reset value of the payload limit register
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1500;

	// ethertype bytes
	localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
	localparam logic [7:0] ETYPE_VLAN_HI = 8'h81;
	localparam logic [7:0] ETYPE_LO      = 8'h00;

	// byte positions of the ethertype, untagged and tagged
	localparam int POS_TYPE_HI      = 12;
	localparam int POS_TYPE_LO      = 13;
	localparam int POS_VLAN_TYPE_HI = 16;
	localparam int POS_VLAN_TYPE_LO = 17;

	// ip header start, untagged and tagged
	localparam logic [4:0] IP_BASE_PLAIN = 5'd14;
	localparam logic [4:0] IP_BASE_VLAN  = 5'd18;

	// offsets inside the ip and tcp headers
	localparam int IP_OFF_VER      = 0;
	localparam int IP_OFF_TLEN_HI  = 2;
	localparam int IP_OFF_TLEN_LO  = 3;
	localparam int IP_OFF_PROTO    = 9;
	localparam int TCP_OFF_DOFF    = 12;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [3:0] VER_IPV4  = 4'd4;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOT_IP  = 3'd1,
		ST_NOT_TCP = 3'd2,
		ST_NOT_IPV4 = 3'd3,
		ST_TRUNC   = 3'd4,
		ST_BAD_LEN = 3'd5
	} status_t;

	// per-frame summary handed from the byte parser to the result stage
	typedef struct packed {
		logic        not_ip;
		logic        no_ip_hdr;
		logic        trunc_ip;
		logic        trunc_tcp;
		logic        is_tcp;
		logic        is_ipv4;
		logic [4:0]  ip_base;
		logic [3:0]  ip_words;
		logic [3:0]  tcp_words;
		logic [15:0] total_length;
		logic        vlan;
	} summary_t;

endpackage

// ===== rtl/eth_ipv4_tcp_header_parser_unit.sv =====
// top level of the ethernet / vlan / ipv4 / tcp header parser
// The parser takes one frame byte per clock cycle while full is low, with
// no gaps needed between frames, and gives one result per frame: a status,
// the byte offset of the tcp payload, its length and the vlan mark. When
// nothing waits ahead of it, the byte parser writes a frame summary into a
// two-entry queue at the edge that takes the frame's last byte, and the
// result stage loads it into the output register at the next one. The input
// only reports full when that queue is full, which takes three short frames
// in a row while pop stays low. Bytes past MAX_FRAME_BYTES are counted no
// further and not inspected. The max_payload register resets to 1500 and
// is written whenever max_payload_we is high.
module eth_ipv4_tcp_header_parser_unit
	import ethp_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	input  logic        max_payload_we,
	input  logic [15:0] max_payload,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  parse_result,
	output logic [7:0]  payload_offset,
	output logic [15:0] payload_length,
	output logic        vlan_tagged
);

	logic     accept;
	logic     sum_push;
	summary_t sum_wdata;
	summary_t sum_rdata;
	logic     sum_empty;
	logic     sum_pop;

	assign accept = push && !full;

	// byte parser
	ethp_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.frame_byte(frame_byte),
		.last_byte (last_byte),
		.sum_push  (sum_push),
		.sum_data  (sum_wdata)
	);

	// summary queue
	ethp_fifo #(
		.WIDTH($bits(summary_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (sum_push),
		.wdata (sum_wdata),
		.full  (full),
		.pop   (sum_pop),
		.rdata (sum_rdata),
		.empty (sum_empty)
	);

	// result stage
	ethp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_payload_we(max_payload_we),
		.max_payload   (max_payload),
		.sum_valid     (!sum_empty),
		.sum_data      (sum_rdata),
		.sum_pop       (sum_pop),
		.pop           (pop),
		.empty         (empty),
		.parse_result  (parse_result),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.vlan_tagged   (vlan_tagged)
	);

endmodule

// ===== rtl/ethp_fifo.sv =====
// small register queue between the byte parser and the result stage
module ethp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ethp_front.sv =====
// byte parser: walks the frame one byte per cycle while accept is high and summarizes it at the last byte
module ethp_front
	import ethp_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] frame_byte,
	input  logic       last_byte,
	output logic       sum_push,
	output summary_t   sum_data
);

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

	logic [IDX_W-1:0] byte_index_q;
	logic [7:0]       type_high_q;
	logic             vlan_q;
	logic [4:0]       ip_base_q;
	logic [3:0]       ver_q;
	logic [3:0]       ihl_q;
	logic [7:0]       proto_q;
	logic [15:0]      tlen_q;
	logic [3:0]       tcpw_q;
	logic             early_q;

	logic [7:0]       type_high_n;
	logic             vlan_n;
	logic [4:0]       ip_base_n;
	logic [3:0]       ver_n;
	logic [3:0]       ihl_n;
	logic [7:0]       proto_n;
	logic [15:0]      tlen_n;
	logic [3:0]       tcpw_n;
	logic             early_n;
	logic [IDX_W-1:0] count_n;

	logic             sat;
	logic             undecided;
	logic [IDX_W-1:0] off;
	logic [IDX_W-1:0] tcp_pos;
	logic [IDX_W-1:0] ip_end_n;
	logic [IDX_W-1:0] tcp_end_n;

	assign sat       = (byte_index_q == IDX_W'(MAX_FRAME_BYTES));
	assign undecided = (ip_base_q == '0) && !early_q;
	assign off       = byte_index_q - IDX_W'(ip_base_q);
	assign tcp_pos   = IDX_W'({ihl_q, 2'b00}) + IDX_W'(TCP_OFF_DOFF);

	// next header state for the byte at hand
	always_comb begin
		type_high_n = type_high_q;
		vlan_n      = vlan_q;
		ip_base_n   = ip_base_q;
		ver_n       = ver_q;
		ihl_n       = ihl_q;
		proto_n     = proto_q;
		tlen_n      = tlen_q;
		tcpw_n      = tcpw_q;
		early_n     = early_q;
		count_n     = byte_index_q;
		if (!sat) begin
			count_n = byte_index_q + 1'b1;
			if (undecided && !vlan_q && byte_index_q == IDX_W'(POS_TYPE_HI)) begin
				type_high_n = frame_byte;
			end else if (undecided && !vlan_q && byte_index_q == IDX_W'(POS_TYPE_LO)) begin
				if (type_high_q == ETYPE_IPV4_HI && frame_byte == ETYPE_LO) begin
					ip_base_n = IP_BASE_PLAIN;
				end else if (type_high_q == ETYPE_VLAN_HI && frame_byte == ETYPE_LO) begin
					vlan_n = 1'b1;
				end else begin
					early_n = 1'b1;
				end
			end else if (undecided && vlan_q && byte_index_q == IDX_W'(POS_VLAN_TYPE_HI)) begin
				type_high_n = frame_byte;
			end else if (undecided && vlan_q && byte_index_q == IDX_W'(POS_VLAN_TYPE_LO)) begin
				if (type_high_q == ETYPE_IPV4_HI && frame_byte == ETYPE_LO) begin
					ip_base_n = IP_BASE_VLAN;
				end else begin
					early_n = 1'b1;
				end
			end else if (ip_base_q != '0 && byte_index_q >= IDX_W'(ip_base_q)) begin
				if (off == IDX_W'(IP_OFF_VER)) begin
					ver_n = frame_byte[7:4];
					ihl_n = frame_byte[3:0];
				end else if (off == IDX_W'(IP_OFF_TLEN_HI)) begin
					tlen_n = {frame_byte, tlen_q[7:0]};
				end else if (off == IDX_W'(IP_OFF_TLEN_LO)) begin
					tlen_n = {tlen_q[15:8], frame_byte};
				end else if (off == IDX_W'(IP_OFF_PROTO)) begin
					proto_n = frame_byte;
				end
				if (off != '0 && off == tcp_pos) begin
					tcpw_n = frame_byte[7:4];
				end
			end
		end
	end

	// truncation limits from the updated header state
	assign ip_end_n  = IDX_W'(ip_base_n) + IDX_W'(IP_OFF_PROTO);
	assign tcp_end_n = IDX_W'(ip_base_n) + IDX_W'({ihl_n, 2'b00}) + IDX_W'(TCP_OFF_DOFF);

	// frame summary
	assign sum_push              = accept && last_byte;
	assign sum_data.not_ip       = early_n;
	assign sum_data.no_ip_hdr    = (ip_base_n == '0);
	assign sum_data.trunc_ip     = (count_n <= ip_end_n);
	assign sum_data.trunc_tcp    = (count_n <= tcp_end_n);
	assign sum_data.is_tcp       = (proto_n == PROTO_TCP);
	assign sum_data.is_ipv4      = (ver_n == VER_IPV4);
	assign sum_data.ip_base      = ip_base_n;
	assign sum_data.ip_words     = ihl_n;
	assign sum_data.tcp_words    = tcpw_n;
	assign sum_data.total_length = tlen_n;
	assign sum_data.vlan         = vlan_n;

	// per-frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			type_high_q  <= '0;
			vlan_q       <= 1'b0;
			ip_base_q    <= '0;
			ver_q        <= '0;
			ihl_q        <= '0;
			proto_q      <= '0;
			tlen_q       <= '0;
			tcpw_q       <= '0;
			early_q      <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				byte_index_q <= '0;
				type_high_q  <= '0;
				vlan_q       <= 1'b0;
				ip_base_q    <= '0;
				ver_q        <= '0;
				ihl_q        <= '0;
				proto_q      <= '0;
				tlen_q       <= '0;
				tcpw_q       <= '0;
				early_q      <= 1'b0;
			end else begin
				byte_index_q <= count_n;
				type_high_q  <= type_high_n;
				vlan_q       <= vlan_n;
				ip_base_q    <= ip_base_n;
				ver_q        <= ver_n;
				ihl_q        <= ihl_n;
				proto_q      <= proto_n;
				tlen_q       <= tlen_n;
				tcpw_q       <= tcpw_n;
				early_q      <= early_n;
			end
		end
	end

endmodule

// ===== rtl/ethp_back.sv =====
// result stage: turns a frame summary into status, payload offset and length
module ethp_back
	import ethp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_payload_we,
	input  logic [15:0] max_payload,
	input  logic        sum_valid,
	input  summary_t    sum_data,
	output logic        sum_pop,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  parse_result,
	output logic [7:0]  payload_offset,
	output logic [15:0] payload_length,
	output logic        vlan_tagged
);

	logic [15:0] max_payload_q;
	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  offset_q;
	logic [15:0] length_q;
	logic        vlan_q;

	status_t     status_c;
	logic [7:0]  offset_c;
	logic [15:0] length_c;
	logic [6:0]  hdrs;
	logic [16:0] diff;
	logic        take;

	// payload limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (max_payload_we) begin
			max_payload_q <= max_payload;
		end
	end

	assign hdrs = {1'b0, sum_data.ip_words, 2'b00} + {1'b0, sum_data.tcp_words, 2'b00};
	assign diff = {1'b0, sum_data.total_length} - 17'(hdrs);

	// status checks in priority order
	always_comb begin
		status_c = ST_OK;
		offset_c = '0;
		length_c = '0;
		if (sum_data.not_ip) begin
			status_c = ST_NOT_IP;
		end else if (sum_data.no_ip_hdr || sum_data.trunc_ip) begin
			status_c = ST_TRUNC;
		end else if (!sum_data.is_tcp) begin
			status_c = ST_NOT_TCP;
		end else if (!sum_data.is_ipv4) begin
			status_c = ST_NOT_IPV4;
		end else if (sum_data.trunc_tcp) begin
			status_c = ST_TRUNC;
		end else begin
			offset_c = 8'(sum_data.ip_base) + 8'(hdrs);
			if (diff[16] || diff[15:0] >= max_payload_q) begin
				status_c = ST_BAD_LEN;
			end else begin
				length_c = diff[15:0];
			end
		end
	end

	// output register, filled when empty or refilled while the held result is taken
	assign take    = sum_valid && (!out_valid_q || pop);
	assign sum_pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_c;
			offset_q <= offset_c;
			length_q <= length_c;
			vlan_q   <= sum_data.vlan;
		end
	end

	assign empty          = !out_valid_q;
	assign parse_result   = status_q;
	assign payload_offset = offset_q;
	assign payload_length = length_q;
	assign vlan_tagged    = vlan_q;

endmodule

// ===== verif/tb_top.sv =====
// testbench for the ethernet / vlan / ipv4 / tcp header parser unit
module tb_top;
	import ethp_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_BYTES  = 550;
	localparam int MAX_PRINTED   = 50;

	// one parse result as seen on the output side
	typedef struct {
		status_t     st;
		logic [7:0]  offset;
		logic [15:0] length;
		logic        vlan;
	} parse_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  frame_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        max_payload_we = 1'b0;
	logic [15:0] max_payload = 16'h0000;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  parse_result;
	logic [7:0]  payload_offset;
	logic [15:0] payload_length;
	logic        vlan_tagged;

	// parser state mirrored by the predictor
	int          m_index;
	logic [7:0]  m_type_hi;
	logic        m_vlan;
	logic [4:0]  m_ip_base;
	logic [3:0]  m_version;
	logic [3:0]  m_ihl;
	logic [7:0]  m_proto;
	logic [15:0] m_total_len;
	logic [3:0]  m_doff;
	logic        m_not_ip;
	logic [15:0] m_max_payload;

	parse_out_t  expected_q[$];
	logic [7:0]  frame_q[$];
	int          errors = 0;
	int          results_seen = 0;
	int          bytes_sent = 0;
	int          cycle_count = 0;
	bit          send_steady = 1'b0;
	bit          pop_steady = 1'b0;
	int          pop_hold = 0;
	int          pop_wait = 0;

	eth_ipv4_tcp_header_parser_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.frame_byte     (frame_byte),
		.last_byte      (last_byte),
		.max_payload_we (max_payload_we),
		.max_payload    (max_payload),
		.empty          (empty),
		.pop            (pop),
		.parse_result   (parse_result),
		.payload_offset (payload_offset),
		.payload_length (payload_length),
		.vlan_tagged    (vlan_tagged)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mismatch report
	task automatic report(input string msg);
		if (errors < MAX_PRINTED)
			$display("mismatch at result %0d: %s", results_seen, msg);
		errors++;
	endtask

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 20);
	endfunction

	task automatic clear_frame_state();
		m_index = 0;
		m_type_hi = '0;
		m_vlan = 1'b0;
		m_ip_base = '0;
		m_version = '0;
		m_ihl = '0;
		m_proto = '0;
		m_total_len = '0;
		m_doff = '0;
		m_not_ip = 1'b0;
	endtask

	// frame-end status, offset and length from the collected header fields
	task automatic close_frame();
		parse_out_t r;
		int ipb;
		int hdrs;
		int tlen;
		ipb = m_ip_base;
		tlen = m_total_len;
		hdrs = int'(m_ihl) * 4 + int'(m_doff) * 4;
		r.offset = '0;
		r.length = '0;
		r.vlan = m_vlan;
		if (m_not_ip)
			r.st = ST_NOT_IP;
		else if (ipb == 0 || m_index <= ipb + IP_OFF_PROTO)
			r.st = ST_TRUNC;
		else if (m_proto != PROTO_TCP)
			r.st = ST_NOT_TCP;
		else if (m_version != VER_IPV4)
			r.st = ST_NOT_IPV4;
		else if (m_index <= ipb + int'(m_ihl) * 4 + TCP_OFF_DOFF)
			r.st = ST_TRUNC;
		else begin
			r.offset = 8'(ipb + hdrs);
			if (tlen < hdrs || tlen - hdrs >= int'(m_max_payload))
				r.st = ST_BAD_LEN;
			else begin
				r.st = ST_OK;
				r.length = 16'(tlen - hdrs);
			end
		end
		expected_q.push_back(r);
		clear_frame_state();
	endtask

	// predictor: one accepted byte
	task automatic parse_model_byte(input logic [7:0] b, input logic last);
		bit undecided;
		int off;
		if (m_index < MAX_FRAME_BYTES_DEF) begin
			undecided = (m_ip_base == 0) && !m_not_ip;
			if (undecided && !m_vlan && m_index == POS_TYPE_HI) begin
				m_type_hi = b;
			end else if (undecided && !m_vlan && m_index == POS_TYPE_LO) begin
				if (m_type_hi == ETYPE_IPV4_HI && b == ETYPE_LO)
					m_ip_base = IP_BASE_PLAIN;
				else if (m_type_hi == ETYPE_VLAN_HI && b == ETYPE_LO)
					m_vlan = 1'b1;
				else
					m_not_ip = 1'b1;
			end else if (undecided && m_vlan && m_index == POS_VLAN_TYPE_HI) begin
				m_type_hi = b;
			end else if (undecided && m_vlan && m_index == POS_VLAN_TYPE_LO) begin
				if (m_type_hi == ETYPE_IPV4_HI && b == ETYPE_LO)
					m_ip_base = IP_BASE_VLAN;
				else
					m_not_ip = 1'b1;
			end else if (m_ip_base != 0 && m_index >= int'(m_ip_base)) begin
				off = m_index - int'(m_ip_base);
				if (off == IP_OFF_VER) begin
					m_version = b[7:4];
					m_ihl = b[3:0];
				end else if (off == IP_OFF_TLEN_HI) begin
					m_total_len[15:8] = b;
				end else if (off == IP_OFF_TLEN_LO) begin
					m_total_len[7:0] = b;
				end else if (off == IP_OFF_PROTO) begin
					m_proto = b;
				end
				if (off >= 1 && off == int'(m_ihl) * 4 + TCP_OFF_DOFF)
					m_doff = b[7:4];
			end
			m_index++;
		end
		if (last)
			close_frame();
	endtask

	// compare one popped result with the oldest expectation
	task automatic check_result();
		parse_out_t e;
		if (expected_q.size() == 0) begin
			report("result with no frame outstanding");
		end else begin
			e = expected_q.pop_front();
			if (parse_result !== e.st)
				report($sformatf("parse_result got %0d expected %0d", parse_result, e.st));
			if (payload_offset !== e.offset)
				report($sformatf("payload_offset got %0d expected %0d",
					payload_offset, e.offset));
			if (payload_length !== e.length)
				report($sformatf("payload_length got %0d expected %0d",
					payload_length, e.length));
			if (vlan_tagged !== e.vlan)
				report($sformatf("vlan_tagged got %0d expected %0d", vlan_tagged, e.vlan));
		end
		results_seen++;
	endtask

	// result side: check each popped transaction, stall pop at random
	always @(posedge clk) begin
		if (pop && !empty)
			check_result();
		if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if (pop_wait > 0) begin
			pop_wait--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!pop_steady)
				pop_wait = pick_gap();
		end
	end

	// cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// send one byte transaction and wait for it to be taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		push <= 1'b1;
		frame_byte <= b;
		last_byte <= last;
		do
			@(posedge clk);
		while (full);
		parse_model_byte(b, last);
		bytes_sent++;
		gap = send_steady ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		int waited;
		waited = 0;
		push <= 1'b0;
		while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_q.size() != 0) begin
			report($sformatf("%0d results never arrived", expected_q.size()));
			expected_q.delete();
		end
	endtask

	// register write on an idle block
	task automatic write_max_payload(input logic [15:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		max_payload_we <= 1'b1;
		max_payload <= v;
		@(posedge clk);
		max_payload_we <= 1'b0;
		m_max_payload = v;
	endtask

	// build a tagged or untagged ipv4 / tcp frame into frame_q
	task automatic build_tcp_frame(input bit vlan, input logic [3:0] ver,
		input logic [3:0] ihl, input logic [3:0] doff, input logic [7:0] proto,
		input logic [15:0] tlen, input int pad);
		int base;
		int len;
		int doff_pos;
		base = vlan ? IP_BASE_VLAN : IP_BASE_PLAIN;
		doff_pos = base + int'(ihl) * 4 + TCP_OFF_DOFF;
		len = doff_pos + 1;
		if (base + int'(ihl) * 4 + int'(doff) * 4 > len)
			len = base + int'(ihl) * 4 + int'(doff) * 4;
		len += pad;
		frame_q.delete();
		for (int i = 0; i < len; i++)
			frame_q.push_back(8'($urandom));
		if (vlan) begin
			frame_q[POS_TYPE_HI] = ETYPE_VLAN_HI;
			frame_q[POS_TYPE_LO] = ETYPE_LO;
			frame_q[POS_VLAN_TYPE_HI] = ETYPE_IPV4_HI;
			frame_q[POS_VLAN_TYPE_LO] = ETYPE_LO;
		end else begin
			frame_q[POS_TYPE_HI] = ETYPE_IPV4_HI;
			frame_q[POS_TYPE_LO] = ETYPE_LO;
		end
		frame_q[base + IP_OFF_VER] = {ver, ihl};
		frame_q[base + IP_OFF_TLEN_HI] = tlen[15:8];
		frame_q[base + IP_OFF_TLEN_LO] = tlen[7:0];
		frame_q[base + IP_OFF_PROTO] = proto;
		frame_q[doff_pos] = {doff, 4'($urandom)};
	endtask

	task automatic trim_frame(input int n);
		while (frame_q.size() > n)
			frame_q.delete(frame_q.size() - 1);
	endtask

	task automatic send_tcp(input bit vlan, input logic [3:0] ver, input logic [3:0] ihl,
		input logic [3:0] doff, input logic [7:0] proto, input logic [15:0] tlen);
		build_tcp_frame(vlan, ver, ihl, doff, proto, tlen, $urandom_range(0, 8));
		send_frame();
	endtask

	// well-formed frames, header length extremes
	task automatic test_well_formed();
		send_tcp(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd60);
		send_tcp(1'b1, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd100);
		send_tcp(1'b0, VER_IPV4, 4'd0, 4'd0, PROTO_TCP, 16'd7);
		send_tcp(1'b1, VER_IPV4, 4'd15, 4'd15, PROTO_TCP, 16'd200);
		send_tcp(1'b0, VER_IPV4, 4'd6, 4'd8, PROTO_TCP, 16'd56);
	endtask

	// foreign ethertypes, second vlan tag
	task automatic test_not_ip();
		build_tcp_frame(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd60, 0);
		frame_q[POS_TYPE_HI] = 8'h86;
		frame_q[POS_TYPE_LO] = 8'hdd;
		send_frame();
		build_tcp_frame(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd60, 0);
		frame_q[POS_TYPE_LO] = 8'h01;
		send_frame();
		build_tcp_frame(1'b1, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd60, 0);
		frame_q[POS_VLAN_TYPE_HI] = ETYPE_VLAN_HI;
		send_frame();
	endtask

	// wrong protocol or version, protocol is checked first
	task automatic test_not_tcp_not_ipv4();
		send_tcp(1'b0, VER_IPV4, 4'd5, 4'd5, 8'd17, 16'd60);
		send_tcp(1'b1, 4'd6, 4'd5, 4'd5, PROTO_TCP, 16'd60);
		send_tcp(1'b0, 4'd6, 4'd5, 4'd5, 8'd17, 16'd60);
	endtask

	// frames cut before or just after the ethertype and before the protocol and data offset bytes
	task automatic test_truncation();
		frame_q.delete();
		frame_q.push_back(8'hff);
		send_frame();
		build_tcp_frame(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd60, 0);
		trim_frame(POS_TYPE_LO + 1);
		send_frame();
		build_tcp_frame(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd60, 0);
		trim_frame(IP_BASE_PLAIN + IP_OFF_PROTO);
		send_frame();
		build_tcp_frame(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd60, 0);
		trim_frame(IP_BASE_PLAIN + 20 + TCP_OFF_DOFF);
		send_frame();
		build_tcp_frame(1'b1, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd60, 0);
		trim_frame(POS_VLAN_TYPE_HI);
		send_frame();
	endtask

	// length underflow and the payload limit boundary at its reset value
	task automatic test_bad_length();
		send_tcp(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd39);
		send_tcp(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'(40 + MAX_PAYLOAD_RST));
		send_tcp(1'b1, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'(39 + MAX_PAYLOAD_RST));
		send_tcp(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'hffff);
	endtask

	// frame longer than the byte counter saturation point
	task automatic test_long_frame();
		build_tcp_frame(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd80,
			MAX_FRAME_BYTES_DEF + 60);
		send_steady = 1'b1;
		send_frame();
		send_steady = 1'b0;
	endtask

	// burst of one-byte frames while pop is held low fills the result queue
	task automatic test_queue_full();
		drain();
		pop_hold = 80;
		send_steady = 1'b1;
		repeat (10) begin
			frame_q.delete();
			frame_q.push_back(8'($urandom));
			send_frame();
		end
		send_steady = 1'b0;
	endtask

	// payload limit at its extremes
	task automatic test_payload_limits();
		write_max_payload(16'd0);
		send_tcp(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd40);
		send_tcp(1'b1, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'd90);
		write_max_payload(16'hffff);
		send_tcp(1'b0, VER_IPV4, 4'd5, 4'd5, PROTO_TCP, 16'hffff);
		send_tcp(1'b1, VER_IPV4, 4'd0, 4'd0, PROTO_TCP, 16'hffff);
	endtask

	// one random frame: mostly well formed, some broken or pure noise
	task automatic build_random_frame();
		int kind;
		int r;
		int hdrs;
		int tlen;
		bit vlan;
		logic [3:0] ihl;
		logic [3:0] doff;
		logic [3:0] ver;
		logic [7:0] proto;
		kind = $urandom_range(0, 99);
		vlan = ($urandom_range(0, 2) == 0);
		ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
		doff = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
		ver = (kind < 80) ? VER_IPV4 : 4'($urandom);
		proto = (kind < 80) ? PROTO_TCP : ($urandom_range(0, 1) ? 8'd17 : 8'($urandom));
		hdrs = int'(ihl) * 4 + int'(doff) * 4;
		r = $urandom_range(0, 99);
		if (r < 65)
			tlen = hdrs + $urandom_range(0, 400);
		else if (r < 80)
			tlen = $urandom_range(0, 65535);
		else if (r < 92)
			tlen = hdrs + int'(m_max_payload) - $urandom_range(0, 1);
		else
			tlen = hdrs - $urandom_range(1, 8);
		if (tlen < 0)
			tlen = 0;
		if (tlen > 65535)
			tlen = 65535;
		build_tcp_frame(vlan, ver, ihl, doff, proto, 16'(tlen), $urandom_range(0, 12));
		if (kind >= 92) begin
			frame_q.delete();
			repeat ($urandom_range(1, 60))
				frame_q.push_back(8'($urandom));
			if ($urandom_range(0, 1) && frame_q.size() > POS_TYPE_LO) begin
				frame_q[POS_TYPE_HI] = ETYPE_IPV4_HI;
				frame_q[POS_TYPE_LO] = ETYPE_LO;
			end
		end else if ($urandom_range(0, 9) == 0) begin
			trim_frame($urandom_range(1, frame_q.size()));
		end else if ($urandom_range(0, 19) == 0) begin
			frame_q[POS_TYPE_HI + (vlan ? 4 : 0) + $urandom_range(0, 1)] = 8'($urandom);
		end
	endtask

	function automatic logic [15:0] pick_max_payload();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 255));
			1: return MAX_PAYLOAD_RST;
			2: return 16'($urandom);
			default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		endcase
	endfunction

	// random traffic in phases with changing limit and idling
	task automatic test_random_traffic();
		int first_byte;
		int phase;
		first_byte = bytes_sent;
		phase = 0;
		while (bytes_sent - first_byte < RANDOM_BYTES) begin
			if (phase % 6 == 0)
				write_max_payload(pick_max_payload());
			else if (phase % 6 == 3)
				drain();
			send_steady = ($urandom_range(0, 3) == 0);
			pop_steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6)) begin
				build_random_frame();
				send_frame();
			end
			phase++;
		end
		send_steady = 1'b0;
		pop_steady = 1'b0;
	endtask

	// main sequence
	initial begin
		m_max_payload = MAX_PAYLOAD_RST;
		clear_frame_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_well_formed();
		test_not_ip();
		test_not_tcp_not_ipv4();
		test_truncation();
		test_bad_length();
		test_long_frame();
		test_queue_full();
		test_payload_limits();
		test_random_traffic();
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ethp_pkg.sv
rtl/ethp_fifo.sv
rtl/ethp_front.sv
rtl/ethp_back.sv
rtl/eth_ipv4_tcp_header_parser_unit.sv
verif/tb_top.sv
